[hdl/xesd_pkg.sv]
`default_nettype none

package xesd_pkg;

  // Depth of the descriptor queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] NAME_COUNT = 3'd5;
  localparam logic [2:0] HELD_MAX   = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
  } out_item_t;

  // One input item's output, as: optional '&', then name_cnt letters of
  // entity name_idx, then an optional tail byte. An item with none of
  // these but eos set yields the empty end marker.
  typedef struct packed {
    logic       lead_amp;
    logic [2:0] name_idx;
    logic [2:0] name_cnt;
    logic       tail_valid;
    logic [7:0] tail_byte;
    logic       eos;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } queue_head_t;

  function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      3'd0: begin
        case (pos)
          3'd0: c = "a";
          3'd1: c = "m";
          3'd2: c = "p";
          3'd3: c = ";";
          default: c = 8'h00;
        endcase
      end
      3'd1: begin
        case (pos)
          3'd0: c = "q";
          3'd1: c = "u";
          3'd2: c = "o";
          3'd3: c = "t";
          3'd4: c = ";";
          default: c = 8'h00;
        endcase
      end
      3'd2: begin
        case (pos)
          3'd0: c = "l";
          3'd1: c = "t";
          3'd2: c = ";";
          default: c = 8'h00;
        endcase
      end
      3'd3: begin
        case (pos)
          3'd0: c = "g";
          3'd1: c = "t";
          3'd2: c = ";";
          default: c = 8'h00;
        endcase
      end
      3'd4: begin
        case (pos)
          3'd0: c = "n";
          3'd1: c = "b";
          3'd2: c = "s";
          3'd3: c = "p";
          3'd4: c = ";";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] name_len(input logic [2:0] idx);
    logic [2:0] n;
    case (idx)
      3'd0:    n = 3'd4;
      3'd1:    n = 3'd5;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd3;
      3'd4:    n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_glyph(input logic [2:0] idx);
    logic [7:0] g;
    case (idx)
      3'd0:    g = CH_AMP;
      3'd1:    g = CH_QUOT;
      3'd2:    g = CH_LT;
      3'd3:    g = CH_GT;
      3'd4:    g = CH_SPACE;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[hdl/xesd_front.sv]
`default_nettype none

module xesd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire xesd_pkg::in_item_t in_item,
  output logic                   push_desc,
  output xesd_pkg::desc_t        desc
);
  import xesd_pkg::*;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_AMP   = 2'd1;
  localparam logic [1:0] MODE_NAME  = 2'd2;
  localparam logic [1:0] MODE_NUM   = 2'd3;

  logic [1:0] mode, mode_next;
  logic [2:0] choice, choice_next;
  logic [2:0] matched, matched_next;
  logic [7:0] value, value_next;
  logic       ended, ended_next;

  logic [7:0] b;
  logic       run_plain;
  logic       first_hit;
  logic [2:0] first_idx;
  logic [2:0] matched_inc;

  assign b = in_item.in_byte;
  assign matched_inc = matched + 3'd1;

  // Which name starts with this letter.
  always_comb begin
    first_hit = 1'b1;
    case (b)
      "a":     first_idx = 3'd0;
      "q":     first_idx = 3'd1;
      "l":     first_idx = 3'd2;
      "g":     first_idx = 3'd3;
      "n":     first_idx = 3'd4;
      default: begin
        first_idx = 3'd0;
        first_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next    = mode;
    choice_next  = choice;
    matched_next = matched;
    value_next   = value;
    ended_next   = ended;
    run_plain    = 1'b0;
    desc         = '0;
    desc.eos     = in_item.end_of_string;

    case (mode)
      MODE_PLAIN: begin
        run_plain = 1'b1;
      end
      MODE_AMP: begin
        if (b == CH_HASH) begin
          mode_next  = MODE_NUM;
          value_next = 8'h00;
          ended_next = 1'b0;
        end else if (first_hit) begin
          mode_next    = MODE_NAME;
          choice_next  = first_idx;
          matched_next = 3'd1;
        end else begin
          desc.lead_amp = 1'b1;
          run_plain     = 1'b1;
        end
      end
      MODE_NAME: begin
        if (choice < NAME_COUNT && matched < name_len(choice) &&
            b == name_char(choice, matched)) begin
          matched_next = matched_inc;
          if (matched_inc == name_len(choice)) begin
            desc.tail_valid = 1'b1;
            desc.tail_byte  = name_glyph(choice);
            mode_next       = MODE_PLAIN;
            matched_next    = 3'd0;
          end
        end else begin
          // Flush '&' and the held letters, then treat the byte as text.
          desc.lead_amp = 1'b1;
          desc.name_idx = choice;
          if (choice < NAME_COUNT) begin
            desc.name_cnt = (matched > HELD_MAX) ? HELD_MAX : matched;
          end
          mode_next    = MODE_PLAIN;
          matched_next = 3'd0;
          run_plain    = 1'b1;
        end
      end
      default: begin
        if (b == CH_SEMI) begin
          desc.tail_valid = 1'b1;
          desc.tail_byte  = value;
          mode_next       = MODE_PLAIN;
        end else if (!ended && (b inside {[CH_ZERO:CH_NINE]})) begin
          value_next = (value << 3) + (value << 1) + (b - CH_ZERO);
        end else begin
          ended_next = 1'b1;
        end
      end
    endcase

    if (run_plain) begin
      if (b == CH_AMP) begin
        mode_next = MODE_AMP;
      end else begin
        desc.tail_valid = 1'b1;
        desc.tail_byte  = (b == CH_PLUS) ? CH_SPACE : b;
        mode_next       = MODE_PLAIN;
      end
    end

    if (in_item.end_of_string) begin
      // Flush a pending name; drop a lone '&' or an open numeric entity.
      if (mode_next == MODE_NAME) begin
        desc.lead_amp = 1'b1;
        desc.name_idx = choice_next;
        if (choice_next < NAME_COUNT) begin
          desc.name_cnt = (matched_next > HELD_MAX) ? HELD_MAX : matched_next;
        end
      end
      mode_next    = MODE_PLAIN;
      choice_next  = 3'd0;
      matched_next = 3'd0;
      value_next   = 8'h00;
      ended_next   = 1'b0;
    end

    push_desc = accept && (desc.lead_amp || desc.name_cnt != 3'd0 ||
                           desc.tail_valid || desc.eos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PLAIN;
      choice  <= 3'd0;
      matched <= 3'd0;
      value   <= 8'h00;
      ended   <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      choice  <= choice_next;
      matched <= matched_next;
      value   <= value_next;
      ended   <= ended_next;
    end
  end

endmodule

`default_nettype wire

[hdl/xesd_fifo.sv]
`default_nettype none

module xesd_fifo #(
  parameter int unsigned DEPTH = xesd_pkg::QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_desc,
  input  wire xesd_pkg::desc_t      desc,
  output logic                      full,
  input  wire logic                 pop_desc,
  output xesd_pkg::queue_head_t     head
);
  import xesd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  desc_t           slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.desc  = slots[rd_ptr];
  assign do_push    = push_desc && !full;
  assign do_pop     = pop_desc && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/xesd_back.sv]
`default_nettype none

module xesd_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire xesd_pkg::queue_head_t head,
  output logic                       pop_desc,
  output logic                       empty,
  input  wire logic                  pop,
  output xesd_pkg::out_item_t        out_item
);
  import xesd_pkg::*;

  logic [2:0] pos;
  logic [2:0] total;
  logic [2:0] letter;
  logic       load;
  logic       last_beat;
  out_item_t  beat;
  logic       out_valid;
  out_item_t  out_reg;

  assign total = {2'b00, head.desc.lead_amp} + head.desc.name_cnt +
                 {2'b00, head.desc.tail_valid};
  assign letter = pos - {2'b00, head.desc.lead_amp};

  always_comb begin
    beat = '0;
    if (head.desc.lead_amp && pos == 3'd0) begin
      beat.out_byte   = CH_AMP;
      beat.byte_valid = 1'b1;
    end else if (letter < head.desc.name_cnt) begin
      beat.out_byte   = name_char(head.desc.name_idx, letter);
      beat.byte_valid = 1'b1;
    end else if (head.desc.tail_valid) begin
      beat.out_byte   = head.desc.tail_byte;
      beat.byte_valid = 1'b1;
    end
    // An empty descriptor is the end marker: one beat with no byte.
    last_beat        = (total == 3'd0) || (pos == total - 3'd1);
    beat.run_last    = last_beat;
    beat.string_done = last_beat && head.desc.eos;
  end

  assign load     = head.valid && (!out_valid || pop);
  assign pop_desc = load && last_beat;
  assign empty    = !out_valid;
  assign out_item = out_reg;

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= last_beat ? 3'd0 : pos + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/xml_entity_stream_decoder_top.sv]
// Streaming XML character-entity decoder. Push one string byte per beat
// (with end_of_string on the final byte); pop decoded bytes one beat at a
// time. '+' turns into a space, the named entities amp, quot, lt, gt and
// nbsp and decimal "&#digits;" entities collapse to one byte, and a broken
// name is replayed literally as '&' plus its letters. Every beat popped
// carries run_last on the last byte caused by an input beat and string_done
// on the last byte of the string; a final byte that yields nothing gives one
// marker beat with byte_valid low. The front classifies each input beat in
// the cycle it is accepted, so input runs at one beat per cycle while the
// descriptor queue (DEPTH entries) has room. The back expands each
// descriptor at one output beat per cycle while the receiver pops: an
// input beat yields at most six bytes (on a name flush), and the queue
// absorbs those bursts. A result passes through the descriptor queue and
// then the output register before it shows on the output.

`default_nettype none

module xml_entity_stream_decoder_top #(
  parameter int unsigned DEPTH = xesd_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire xesd_pkg::in_item_t in_item,
  output logic                    empty,
  input  wire logic               pop,
  output xesd_pkg::out_item_t     out_item
);
  import xesd_pkg::*;

  logic        accept;
  logic        push_desc;
  desc_t       desc;
  logic        pop_desc;
  queue_head_t head;

  // Take a beat whenever the queue has room.
  assign accept = push && !full;

  // Front: track entity parse state and describe each beat's output.
  xesd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_item   (in_item),
    .push_desc (push_desc),
    .desc      (desc)
  );

  // Queue: decouple classification from byte-by-byte expansion.
  xesd_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_desc (push_desc),
    .desc      (desc),
    .full      (full),
    .pop_desc  (pop_desc),
    .head      (head)
  );

  // Back: walk each descriptor and drive the output register.
  xesd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop_desc (pop_desc),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

`ifndef SYNTH
  // The front never writes a descriptor the queue cannot hold.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_desc |-> !full)
    else $error("descriptor pushed into a full queue");

  // A byte-less beat is only ever the end-of-string marker.
  a_marker_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.byte_valid) |->
      (out_item.run_last && out_item.string_done && out_item.out_byte == 8'h00))
    else $error("malformed end marker beat");

  // The queue only drains descriptors that are there.
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop_desc |-> head.valid)
    else $error("descriptor popped from an empty queue");
`endif

endmodule

`default_nettype wire

[sim/tb_top.sv]
module tb_top;
  import xesd_pkg::*;

  // Stall limit for the watchdog: the receiver hold-off below is the longest
  // legal quiet stretch, so allow it many times over.
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {MODE_TEXT, MODE_AMP, MODE_NAME, MODE_NUM} dec_mode_e;

  // One row of the directed script. When fixed is set, the beats the row
  // must produce are typed in here (none or one byte); otherwise the
  // decoder model decides.
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       fixed;
    logic       n_out;
    logic [7:0] b_out;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  // Decoder model state.
  dec_mode_e  mode_q   = MODE_TEXT;
  logic [2:0] ent_sel  = 3'd0;
  logic [2:0] ent_held = 3'd0;
  logic [7:0] num_acc  = 8'd0;
  logic       num_done = 1'b0;
  logic [7:0] glyphs[$];
  out_item_t  step_out[$];
  out_item_t  due_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req      = 1'b0;
  int err_count     = 0;
  int beats_sent    = 0;
  int quiet_cycles  = 0;

  // Walk this top to bottom: byte extremes, '+', each entity path, the
  // "&&" restart, numeric wrap, and the end-of-string drops and flushes.
  stim_row_t script [27] = '{
    '{8'h00,    1'b0, 1'b1, 1'b1, 8'h00},     // low byte passes through
    '{8'hFF,    1'b0, 1'b1, 1'b1, 8'hFF},     // high byte passes through
    '{CH_PLUS,  1'b0, 1'b1, 1'b1, CH_SPACE},  // plus becomes space
    '{CH_AMP,   1'b0, 1'b1, 1'b0, 8'h00},
    '{"l",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"t",      1'b0, 1'b0, 1'b0, 8'h00},
    '{CH_SEMI,  1'b0, 1'b1, 1'b1, CH_LT},     // &lt; collapses to '<'
    '{CH_AMP,   1'b0, 1'b1, 1'b0, 8'h00},
    '{"n",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"b",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"s",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"p",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"x",      1'b0, 1'b0, 1'b0, 8'h00},     // broken name: six beats out
    '{CH_AMP,   1'b0, 1'b1, 1'b0, 8'h00},
    '{CH_AMP,   1'b0, 1'b1, 1'b1, CH_AMP},    // second '&' reopens an entity
    '{CH_HASH,  1'b0, 1'b1, 1'b0, 8'h00},
    '{"9",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"9",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"9",      1'b0, 1'b0, 1'b0, 8'h00},
    '{CH_SEMI,  1'b0, 1'b0, 1'b0, 8'h00},     // value wraps modulo 256
    '{CH_AMP,   1'b1, 1'b1, 1'b0, 8'h00},     // trailing '&' dropped: marker
    '{CH_AMP,   1'b0, 1'b1, 1'b0, 8'h00},
    '{"g",      1'b0, 1'b0, 1'b0, 8'h00},
    '{"t",      1'b1, 1'b0, 1'b0, 8'h00},     // pending name flushed at end
    '{CH_AMP,   1'b0, 1'b1, 1'b0, 8'h00},
    '{CH_HASH,  1'b0, 1'b1, 1'b0, 8'h00},
    '{CH_SEMI,  1'b1, 1'b1, 1'b1, 8'h00}      // no digits gives zero
  };

  xml_entity_stream_decoder_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Entity tables
  // ---------------------------------------------------------------------
  function automatic logic [0:4][7:0] spelling(input logic [2:0] idx);
    case (idx)
      3'd0:    return {"amp;", 8'h00};
      3'd1:    return "quot;";
      3'd2:    return {"lt;", 16'h0000};
      3'd3:    return {"gt;", 16'h0000};
      default: return "nbsp;";
    endcase
  endfunction

  function automatic logic [2:0] spelled_len(input logic [2:0] idx);
    case (idx)
      3'd0:    return 3'd4;
      3'd2:    return 3'd3;
      3'd3:    return 3'd3;
      default: return 3'd5;
    endcase
  endfunction

  function automatic logic [7:0] entity_glyph(input logic [2:0] idx);
    case (idx)
      3'd0:    return CH_AMP;
      3'd1:    return CH_QUOT;
      3'd2:    return CH_LT;
      3'd3:    return CH_GT;
      default: return CH_SPACE;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------
  function automatic void push_glyph(input logic [7:0] b);
    if (glyphs.size() < 6) glyphs.push_back(b);
  endfunction

  function automatic void take_plain(input logic [7:0] b);
    if (b == CH_AMP) begin
      mode_q = MODE_AMP;
    end else begin
      push_glyph((b == CH_PLUS) ? CH_SPACE : b);
      mode_q = MODE_TEXT;
    end
  endfunction

  // Replay '&' and whatever letters of the name were held.
  function automatic void replay_name();
    logic [0:4][7:0] sp;
    sp = spelling(ent_sel);
    push_glyph(CH_AMP);
    if (ent_sel < NAME_COUNT) begin
      for (int i = 0; i < ent_held && i < 4; i++) push_glyph(sp[i]);
    end
    mode_q = MODE_TEXT;
    ent_held = 3'd0;
  endfunction

  // Advance the model by one input byte; leave the beats it yields in step_out.
  function automatic void decode_char(input in_item_t it);
    logic [7:0]      b;
    logic [0:4][7:0] sp;
    int              hit;
    b = it.in_byte;
    glyphs.delete();
    step_out.delete();
    case (mode_q)
      MODE_TEXT: begin
        take_plain(b);
      end
      MODE_AMP: begin
        if (b == CH_HASH) begin
          mode_q = MODE_NUM;
          num_acc = 8'd0;
          num_done = 1'b0;
        end else begin
          hit = -1;
          for (int k = 4; k >= 0; k--) begin
            sp = spelling(3'(k));
            if (sp[0] == b) hit = k;
          end
          if (hit >= 0) begin
            mode_q = MODE_NAME;
            ent_sel = 3'(hit);
            ent_held = 3'd1;
          end else begin
            push_glyph(CH_AMP);
            take_plain(b);
          end
        end
      end
      MODE_NAME: begin
        sp = spelling(ent_sel);
        if (ent_sel < NAME_COUNT && ent_held < spelled_len(ent_sel) && b == sp[ent_held]) begin
          ent_held = ent_held + 3'd1;
          if (ent_held == spelled_len(ent_sel)) begin
            push_glyph(entity_glyph(ent_sel));
            mode_q = MODE_TEXT;
            ent_held = 3'd0;
          end
        end else begin
          replay_name();
          take_plain(b);
        end
      end
      default: begin
        if (b == CH_SEMI) begin
          push_glyph(num_acc);
          mode_q = MODE_TEXT;
        end else if (!num_done && b >= CH_ZERO && b <= CH_NINE) begin
          num_acc = num_acc * 8'd10 + (b - CH_ZERO);
        end else begin
          num_done = 1'b1;
        end
      end
    endcase

    // End of string: flush a held name, drop anything else, clear state.
    if (it.end_of_string) begin
      if (mode_q == MODE_NAME) replay_name();
      mode_q = MODE_TEXT;
      ent_sel = 3'd0;
      ent_held = 3'd0;
      num_acc = 8'd0;
      num_done = 1'b0;
    end

    if (glyphs.size() == 0) begin
      if (it.end_of_string) step_out.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    end else begin
      foreach (glyphs[r]) begin
        step_out.push_back('{glyphs[r], 1'b1, r == glyphs.size() - 1,
                             (r == glyphs.size() - 1) && it.end_of_string});
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------
  // Offer one beat; call at a falling edge, return at a falling edge with
  // push still high so back-to-back beats never drop it.
  task automatic send_beat(input stim_row_t row);
    in_item_t it;
    it.in_byte = row.ch;
    it.end_of_string = row.eos;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    // Accepted at this edge: advance the model now, before the first
    // result of this beat can show up on the output.
    decode_char(it);
    if (row.fixed) begin
      step_out.delete();
      if (row.n_out) step_out.push_back('{row.b_out, 1'b1, 1'b1, row.eos});
      else if (row.eos) step_out.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    end
    foreach (step_out[i]) due_bytes.push_back(step_out[i]);
    beats_sent++;
    @(negedge clk);
  endtask

  // Build one string out of random pieces, mostly well-formed entities,
  // with stray bytes and broken names mixed in, then send it.
  task automatic send_random_string();
    logic [7:0]      text[$];
    logic [0:4][7:0] sp;
    logic [2:0]      k;
    logic [7:0]      junk;
    int              kind;
    int              n;
    stim_row_t       row;
    for (int p = $urandom_range(1, 5); p > 0; p--) begin
      kind = $urandom_range(0, 19);
      k = 3'($urandom_range(0, 4));
      sp = spelling(k);
      if (kind < 4) begin
        text.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 4) begin
        text.push_back(CH_PLUS);
      end else if (kind < 7) begin
        for (int i = $urandom_range(1, 3); i > 0; i--)
          text.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end else if (kind < 12) begin
        text.push_back(CH_AMP);
        for (int i = 0; i < spelled_len(k); i++) text.push_back(sp[i]);
      end else if (kind < 15) begin
        text.push_back(CH_AMP);
        text.push_back(CH_HASH);
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          // Trailing junk after the digits; later digits must be ignored.
          junk = 8'($urandom_range(0, 255));
          text.push_back((junk == CH_SEMI) ? 8'h78 : junk);
          text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        text.push_back(CH_SEMI);
      end else if (kind < 17) begin
        text.push_back(CH_AMP);
        n = $urandom_range(1, spelled_len(k) - 1);
        for (int i = 0; i < n; i++) text.push_back(sp[i]);
        text.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 17) begin
        text.push_back(CH_AMP);
        text.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 18) begin
        // Unfinished entity; if it lands at the end it gets dropped or flushed.
        text.push_back(CH_AMP);
        if ($urandom_range(0, 1)) begin
          n = $urandom_range(0, spelled_len(k) - 1);
          for (int i = 0; i < n; i++) text.push_back(sp[i]);
        end else begin
          text.push_back(CH_HASH);
          for (int i = $urandom_range(0, 3); i > 0; i--)
            text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end else begin
        text.push_back(CH_AMP);
        text.push_back(CH_AMP);
      end
    end
    foreach (text[i]) begin
      row = '{text[i], i == text.size() - 1, 1'b0, 1'b0, 8'h00};
      send_beat(row);
    end
  endtask

  task automatic run_random(input int n_beats);
    int start;
    start = beats_sent;
    while (beats_sent - start < n_beats) send_random_string();
  endtask

  // ---------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------
  // Decide pop at each falling edge; on request, hold pop low for a long
  // stretch so the queue fills and full pushes back on the sender.
  initial begin : receiver
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // Check every popped beat against the oldest expected one, field by field.
  always @(posedge clk) begin : check_beat
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (due_bytes.size() == 0) begin
        report_mismatch($sformatf("beat %h with nothing expected", out_item));
      end else begin
        want = due_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", out_item.out_byte, want.out_byte));
        if (out_item.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b",
                                    out_item.byte_valid, want.byte_valid));
        if (out_item.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %b, want %b", out_item.run_last, want.run_last));
        if (out_item.string_done !== want.string_done)
          report_mismatch($sformatf("string_done %b, want %b",
                                    out_item.string_done, want.string_done));
      end
    end
  end

  // Watchdog: end the run once nothing has moved on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    send_idle_pct = 21;
    recv_idle_pct = 58;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed script first.
    foreach (script[i]) send_beat(script[i]);

    // Random strings: slow receiver, then slow sender, then full speed
    // with one long receiver hold-off to back the queue up.
    run_random(100);
    send_idle_pct = 58;
    recv_idle_pct = 21;
    run_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(100);
    push <= 1'b0;

    // Drain, then give the block a little longer to show any stray beat.
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
